// ===== rtl/aom_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aom_pkg
// Shared widths, register indexes, reset values and command type for the
// autoranging ohmmeter unit and its serial arithmetic units.
// ----------------------------------------------------------------------------
package aom_pkg;

	localparam int NUM_RANGES_DEF  = 5;
	localparam int SAMPLE_BITS_DEF = 10;

	localparam int RANGE_W   = 3;
	localparam int SUPPLY_W  = 16;
	localparam int FS_W      = 11;
	localparam int REF_W     = 24;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 24;
	localparam int OHMS_W    = 32;
	localparam int UNIT_W    = 2;
	localparam int WHOLE_W   = 13;
	localparam int FRAC_W    = 10;

	localparam int NUM_REFS  = 5;
	localparam int REF_IDX_W = 3;

	// serial multiplier and divider sizes
	localparam int MUL_AW = 16;
	localparam int MUL_BW = 24;
	localparam int MUL_PW = 40;
	localparam int DIV_NW = 40;
	localparam int DIV_DW = 16;
	localparam int STEP_W = 6;

	// kilo-ohm quotient of a 32-bit value fits in this many bits
	localparam int Q1_W = 23;

	localparam logic [CFG_IDX_W-1:0] REG_SUPPLY     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DROP       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REF_100    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REF_1K     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_REF_10K    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_REF_100K   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_REF_1M     = 3'd7;

	localparam logic [SUPPLY_W-1:0] SUPPLY_RST     = 16'd5000;
	localparam logic [SUPPLY_W-1:0] DROP_RST       = 16'd700;
	localparam logic [FS_W-1:0]     FULL_SCALE_RST = 11'd1024;
	localparam logic [REF_W-1:0]    REF_100_RST    = 24'd100;
	localparam logic [REF_W-1:0]    REF_1K_RST     = 24'd1000;
	localparam logic [REF_W-1:0]    REF_10K_RST    = 24'd10000;
	localparam logic [REF_W-1:0]    REF_100K_RST   = 24'd100000;
	localparam logic [REF_W-1:0]    REF_1M_RST     = 24'd1000000;

	localparam logic [15:0]       LOW_LIMIT  = 16'd100;
	localparam logic [15:0]       OPEN_LIMIT = 16'd950;
	localparam logic [DIV_DW-1:0] KILO_DIV   = 16'd1000;
	localparam logic [OHMS_W-1:0] KILO       = 32'd1000;
	localparam logic [OHMS_W-1:0] MEGA       = 32'd1000000;

	localparam logic [UNIT_W-1:0] UNIT_OHM  = 2'd0;
	localparam logic [UNIT_W-1:0] UNIT_KOHM = 2'd1;
	localparam logic [UNIT_W-1:0] UNIT_MOHM = 2'd2;

	typedef struct packed {
		logic              start;
		logic [STEP_W-1:0] steps;
	} ser_cmd_t;

endpackage

// ===== rtl/aom_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aom_mul
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle, MSB
// first. The multiplier operand is left-aligned; steps gives its bit count.
// ----------------------------------------------------------------------------
module aom_mul import aom_pkg::*; #(
	parameter int AW = MUL_AW,
	parameter int BW = MUL_BW,
	parameter int PW = MUL_PW
) (
	input  logic          clk,
	input  logic          arst_n,
	input  ser_cmd_t      cmd,
	input  logic [AW-1:0] a,
	input  logic [BW-1:0] b,
	output logic          done,
	output logic [PW-1:0] prod
);

	logic [AW-1:0]     a_q;
	logic [BW-1:0]     b_q;
	logic [PW-1:0]     acc_q;
	logic [PW-1:0]     acc_next;
	logic [STEP_W-1:0] cnt_q;
	logic              run_q;
	logic              done_q;

	assign acc_next = {acc_q[PW-2:0], 1'b0} + (a_q[AW-1] ? PW'(b_q) : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				run_q <= 1'b1;
				cnt_q <= cmd.steps;
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (run_q) begin
			a_q   <= {a_q[AW-2:0], 1'b0};
			acc_q <= acc_next;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

// ===== rtl/aom_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aom_div
// Restoring serial divider, one quotient bit per cycle. The dividend is
// left-aligned; when done is raised the quotient sits in the low steps bits.
// ----------------------------------------------------------------------------
module aom_div import aom_pkg::*; #(
	parameter int NW = DIV_NW,
	parameter int DW = DIV_DW
) (
	input  logic          clk,
	input  logic          arst_n,
	input  ser_cmd_t      cmd,
	input  logic [NW-1:0] numer,
	input  logic [DW-1:0] denom,
	output logic          done,
	output logic [NW-1:0] quot,
	output logic [DW-1:0] rem
);

	logic [NW-1:0]     num_q;
	logic [DW-1:0]     den_q;
	logic [DW-1:0]     rem_q;
	logic [DW:0]       trial;
	logic [DW:0]       diff;
	logic              qbit;
	logic [STEP_W-1:0] cnt_q;
	logic              run_q;
	logic              done_q;

	assign trial = {rem_q, num_q[NW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign qbit  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				run_q <= 1'b1;
				cnt_q <= cmd.steps;
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			num_q <= numer;
			den_q <= denom;
			rem_q <= '0;
		end else if (run_q) begin
			num_q <= {num_q[NW-2:0], qbit};
			rem_q <= qbit ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	assign done = done_q;
	assign quot = num_q;
	assign rem  = rem_q;

endmodule

// ===== rtl/autorange_ohmmeter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// autorange_ohmmeter_unit
// Autoranging divider ohmmeter: steps the reference range down on low
// samples; otherwise it flags an open circuit or works out the resistance
// and its display split with a shared bit-serial multiplier and divider.
// ----------------------------------------------------------------------------
//  channel   handshake                     payload
//  sample    sample_valid / sample_ready   adc_sample
//  result    result_valid / result_ready   range_select, reading_done,
//                                          open_circuit, ohms, unit_code,
//                                          whole_part, fraction_part
//  config    cfg_we                        cfg_index, cfg_data
//
//  A range step-down or an open circuit on a high sample goes from S_EVAL
//  straight to S_DONE. A full reading runs the bit-serial multiplier and
//  the one-bit-per-cycle divider in turn, the second divide a 40-bit pass.
//  One transaction is in work at a time; sample_ready is high while idle,
//  even when a result still waits in the output register.
//  Reset puts the unit on the top range with the default register values.
// ----------------------------------------------------------------------------
module autorange_ohmmeter_unit import aom_pkg::*; #(
	parameter int NUM_RANGES  = NUM_RANGES_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   sample_valid,
	output logic                   sample_ready,
	input  logic [SAMPLE_BITS-1:0] adc_sample,
	output logic                   result_valid,
	input  logic                   result_ready,
	output logic [RANGE_W-1:0]     range_select,
	output logic                   reading_done,
	output logic                   open_circuit,
	output logic [OHMS_W-1:0]      ohms,
	output logic [UNIT_W-1:0]      unit_code,
	output logic [WHOLE_W-1:0]     whole_part,
	output logic [FRAC_W-1:0]      fraction_part,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_data
);

	localparam logic [RANGE_W-1:0] TOP_RANGE = RANGE_W'(NUM_RANGES - 1);
	localparam int V_NUM_W = SAMPLE_BITS + SUPPLY_W + 1;

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_EVAL = 9'b000000010,
		S_MUL1 = 9'b000000100,
		S_DIV1 = 9'b000001000,
		S_MUL2 = 9'b000010000,
		S_DIV2 = 9'b000100000,
		S_SPL1 = 9'b001000000,
		S_SPL2 = 9'b010000000,
		S_DONE = 9'b100000000
	} state_t;

	state_t state_q;

	logic [SUPPLY_W-1:0] supply_q;
	logic [SUPPLY_W-1:0] drop_q;
	logic [FS_W-1:0]     fs_q;
	logic [REF_W-1:0]    ref_q [NUM_REFS];
	logic [RANGE_W-1:0]  range_q;

	logic [SAMPLE_BITS-1:0] sample_q;
	logic [RANGE_W-1:0]     idx_q;
	logic [SUPPLY_W-1:0]    vout_q;

	logic                res_done_q;
	logic                res_open_q;
	logic [RANGE_W-1:0]  res_range_q;
	logic [OHMS_W-1:0]   res_ohms_q;
	logic [UNIT_W-1:0]   res_unit_q;
	logic [WHOLE_W-1:0]  res_whole_q;
	logic [FRAC_W-1:0]   res_frac_q;

	logic                out_valid_q;
	logic                out_done_q;
	logic                out_open_q;
	logic [RANGE_W-1:0]  out_range_q;
	logic [OHMS_W-1:0]   out_ohms_q;
	logic [UNIT_W-1:0]   out_unit_q;
	logic [WHOLE_W-1:0]  out_whole_q;
	logic [FRAC_W-1:0]   out_frac_q;

	ser_cmd_t            mul_cmd;
	logic [MUL_AW-1:0]   mul_a;
	logic [MUL_BW-1:0]   mul_b;
	logic                mul_done;
	logic [MUL_PW-1:0]   mul_prod;

	ser_cmd_t            div_cmd;
	logic [DIV_NW-1:0]   div_numer;
	logic [DIV_DW-1:0]   div_denom;
	logic                div_done;
	logic [DIV_NW-1:0]   div_quot;
	logic [DIV_DW-1:0]   div_rem;

	logic                step_down;
	logic                open_sample;
	logic                vout_open;
	logic                out_free;
	logic [OHMS_W-1:0]   sat_ohms;
	logic [DIV_DW-1:0]   fs_eff;
	logic [REF_W-1:0]    ref_sel;
	logic [RANGE_W-1:0]  idx_clamp;

	assign step_down   = (16'(sample_q) < LOW_LIMIT) && (idx_q != '0);
	assign open_sample = (16'(sample_q) >= OPEN_LIMIT);
	assign vout_open   = (div_quot >= DIV_NW'(supply_q));
	assign sat_ohms    = (|div_quot[DIV_NW-1:OHMS_W]) ? '1 : div_quot[OHMS_W-1:0];
	assign fs_eff      = (fs_q == '0) ? DIV_DW'(1) : DIV_DW'(fs_q);
	assign ref_sel     = (idx_q > REF_IDX_W'(NUM_REFS - 1)) ? ref_q[NUM_REFS-1] : ref_q[idx_q];
	assign idx_clamp   = (range_q > TOP_RANGE) ? TOP_RANGE : range_q;
	assign out_free    = !out_valid_q || result_ready;

	aom_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mul_cmd),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	aom_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (div_cmd),
		.numer  (div_numer),
		.denom  (div_denom),
		.done   (div_done),
		.quot   (div_quot),
		.rem    (div_rem)
	);

	// operand steering for the shared serial units
	always_comb begin
		mul_cmd   = '0;
		mul_a     = '0;
		mul_b     = '0;
		div_cmd   = '0;
		div_numer = '0;
		div_denom = '0;
		unique case (state_q)
			S_EVAL: begin
				if (!step_down && !open_sample) begin
					mul_cmd.start = 1'b1;
					mul_cmd.steps = STEP_W'(SAMPLE_BITS);
					mul_a = MUL_AW'(sample_q) << (MUL_AW - SAMPLE_BITS);
					mul_b = MUL_BW'({1'b0, supply_q} + {1'b0, drop_q});
				end
			end
			S_MUL1: begin
				if (mul_done) begin
					div_cmd.start = 1'b1;
					div_cmd.steps = STEP_W'(V_NUM_W);
					div_numer = DIV_NW'(mul_prod) << (DIV_NW - V_NUM_W);
					div_denom = fs_eff;
				end
			end
			S_DIV1: begin
				if (div_done && !vout_open) begin
					mul_cmd.start = 1'b1;
					mul_cmd.steps = STEP_W'(SUPPLY_W);
					mul_a = MUL_AW'(div_quot[SUPPLY_W-1:0]);
					mul_b = MUL_BW'(ref_sel);
				end
			end
			S_MUL2: begin
				if (mul_done) begin
					div_cmd.start = 1'b1;
					div_cmd.steps = STEP_W'(DIV_NW);
					div_numer = DIV_NW'(mul_prod);
					div_denom = supply_q - vout_q;
				end
			end
			S_DIV2: begin
				if (div_done && sat_ohms >= KILO) begin
					div_cmd.start = 1'b1;
					div_cmd.steps = STEP_W'(OHMS_W);
					div_numer = DIV_NW'(sat_ohms) << (DIV_NW - OHMS_W);
					div_denom = KILO_DIV;
				end
			end
			S_SPL1: begin
				if (div_done && res_ohms_q >= MEGA) begin
					div_cmd.start = 1'b1;
					div_cmd.steps = STEP_W'(Q1_W);
					div_numer = DIV_NW'(div_quot[Q1_W-1:0]) << (DIV_NW - Q1_W);
					div_denom = KILO_DIV;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			range_q     <= TOP_RANGE;
			out_valid_q <= 1'b0;
			supply_q    <= SUPPLY_RST;
			drop_q      <= DROP_RST;
			fs_q        <= FULL_SCALE_RST;
			ref_q[0]    <= REF_100_RST;
			ref_q[1]    <= REF_1K_RST;
			ref_q[2]    <= REF_10K_RST;
			ref_q[3]    <= REF_100K_RST;
			ref_q[4]    <= REF_1M_RST;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_SUPPLY:     supply_q <= cfg_data[SUPPLY_W-1:0];
					REG_DROP:       drop_q   <= cfg_data[SUPPLY_W-1:0];
					REG_FULL_SCALE: fs_q     <= cfg_data[FS_W-1:0];
					REG_REF_100:    ref_q[0] <= cfg_data[REF_W-1:0];
					REG_REF_1K:     ref_q[1] <= cfg_data[REF_W-1:0];
					REG_REF_10K:    ref_q[2] <= cfg_data[REF_W-1:0];
					REG_REF_100K:   ref_q[3] <= cfg_data[REF_W-1:0];
					REG_REF_1M:     ref_q[4] <= cfg_data[REF_W-1:0];
					default: begin
					end
				endcase
			end

			if (out_valid_q && result_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (sample_valid) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (step_down || open_sample) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_MUL1;
					end
				end
				S_MUL1: begin
					if (mul_done) begin
						state_q <= S_DIV1;
					end
				end
				S_DIV1: begin
					if (div_done) begin
						state_q <= vout_open ? S_DONE : S_MUL2;
					end
				end
				S_MUL2: begin
					if (mul_done) begin
						state_q <= S_DIV2;
					end
				end
				S_DIV2: begin
					if (div_done) begin
						state_q <= (sat_ohms < KILO) ? S_DONE : S_SPL1;
					end
				end
				S_SPL1: begin
					if (div_done) begin
						state_q <= (res_ohms_q < MEGA) ? S_DONE : S_SPL2;
					end
				end
				S_SPL2: begin
					if (div_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						range_q     <= res_range_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// working and output payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (sample_valid) begin
					sample_q <= adc_sample;
					idx_q    <= idx_clamp;
				end
			end
			S_EVAL: begin
				res_done_q  <= !step_down;
				res_open_q  <= !step_down && open_sample;
				res_range_q <= step_down ? idx_q - 1'b1 : TOP_RANGE;
				res_ohms_q  <= '0;
				res_unit_q  <= UNIT_OHM;
				res_whole_q <= '0;
				res_frac_q  <= '0;
			end
			S_DIV1: begin
				if (div_done) begin
					vout_q     <= div_quot[SUPPLY_W-1:0];
					res_open_q <= vout_open;
				end
			end
			S_DIV2: begin
				if (div_done) begin
					res_ohms_q  <= sat_ohms;
					res_whole_q <= sat_ohms[WHOLE_W-1:0];
				end
			end
			S_SPL1: begin
				if (div_done) begin
					res_unit_q  <= UNIT_KOHM;
					res_whole_q <= div_quot[WHOLE_W-1:0];
					res_frac_q  <= div_rem[FRAC_W-1:0];
				end
			end
			S_SPL2: begin
				if (div_done) begin
					res_unit_q  <= UNIT_MOHM;
					res_whole_q <= div_quot[WHOLE_W-1:0];
					res_frac_q  <= div_rem[FRAC_W-1:0];
				end
			end
			S_DONE: begin
				if (out_free) begin
					out_range_q <= res_range_q;
					out_done_q  <= res_done_q;
					out_open_q  <= res_open_q;
					out_ohms_q  <= res_ohms_q;
					out_unit_q  <= res_unit_q;
					out_whole_q <= res_whole_q;
					out_frac_q  <= res_frac_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign sample_ready  = (state_q == S_IDLE);
	assign result_valid  = out_valid_q;
	assign range_select  = out_range_q;
	assign reading_done  = out_done_q;
	assign open_circuit  = out_open_q;
	assign ohms          = out_ohms_q;
	assign unit_code     = out_unit_q;
	assign whole_part    = out_whole_q;
	assign fraction_part = out_frac_q;

endmodule
